// ===== rtl/next_contact_time_search_unit_assert.svh =====
// Assertion macros shared by the next contact time search unit.
// Each macro expects signals named clk and rst in the including module.
`ifndef NEXT_CONTACT_TIME_SEARCH_UNIT_ASSERT_SVH
`define NEXT_CONTACT_TIME_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NCTS_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NCTS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/ncts_pkg.sv =====
// Package for the next contact time search unit: sizes, codes and item types.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ncts_pkg;

  localparam int MAX_CONTACTS = 1024;
  localparam int ADDR_W = $clog2(MAX_CONTACTS);
  localparam int COUNT_W = $clog2(MAX_CONTACTS + 1);
  localparam int TIME_W = 32;
  localparam int SKIP_W = 16;
  localparam int SEL_W = ((ADDR_W > SKIP_W) ? ADDR_W : SKIP_W) + 1;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;

  typedef enum logic [1:0] {
    RD_LAST,
    RD_INIT,
    RD_STEP,
    RD_SEL
  } rd_sel_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] time_value;
    logic [SKIP_W-1:0] skip_count;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] contact_time;
  } rsp_t;

  typedef struct packed {
    logic       do_clear;
    logic       do_append;
    logic       latch_query;
    logic       init_search;
    logic       step_search;
    logic       set_result;
    logic [1:0] result_code;
    logic       out_load;
    rd_sel_t    rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_le;
    logic init_cont;
    logic step_cont;
    logic sel_past;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/ncts_datapath.sv =====
// Datapath of the next contact time search unit: contact memory, count,
// bisection bounds, result and output registers. Depends on ncts_pkg.
`timescale 1ns / 1ps
`include "next_contact_time_search_unit_assert.svh"

module ncts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ncts_pkg::req_t      req,
  input  ncts_pkg::dp_cmd_t   cmd,
  output ncts_pkg::dp_status_t status,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ncts_pkg::rsp_t      rsp
);

  logic [ncts_pkg::TIME_W-1:0]  mem [ncts_pkg::MAX_CONTACTS];
  logic [ncts_pkg::TIME_W-1:0]  rdata;
  logic [ncts_pkg::TIME_W-1:0]  now;
  logic [ncts_pkg::SKIP_W-1:0]  skip;
  logic [ncts_pkg::COUNT_W-1:0] count;
  logic [ncts_pkg::COUNT_W-1:0] count_m1;
  logic                         not_full;
  logic [ncts_pkg::ADDR_W-1:0]  lo;
  logic [ncts_pkg::ADDR_W-1:0]  hi;
  logic [ncts_pkg::ADDR_W-1:0]  mid;
  logic [ncts_pkg::ADDR_W-1:0]  lo_next;
  logic [ncts_pkg::ADDR_W-1:0]  hi_next;
  logic [ncts_pkg::ADDR_W-1:0]  mid_next;
  logic [ncts_pkg::ADDR_W-1:0]  last_idx;
  logic [ncts_pkg::ADDR_W-1:0]  mid_init;
  logic [ncts_pkg::ADDR_W-1:0]  hsel;
  logic [ncts_pkg::ADDR_W-1:0]  raddr;
  logic [ncts_pkg::ADDR_W:0]    sum_next;
  logic                         gt;
  logic                         init_cont;
  logic                         step_cont;
  logic [ncts_pkg::SEL_W-1:0]   sel_sum;
  logic [1:0]                   res_status;
  logic [ncts_pkg::TIME_W-1:0]  res_time;

  always_comb begin
    count_m1 = count - ncts_pkg::COUNT_W'(1);
    last_idx = count_m1[ncts_pkg::ADDR_W-1:0];
    not_full = count < ncts_pkg::COUNT_W'(ncts_pkg::MAX_CONTACTS);
    gt = rdata > now;
    lo_next = gt ? lo : mid;
    hi_next = gt ? mid : hi;
    sum_next = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = sum_next[ncts_pkg::ADDR_W:1];
    step_cont = {1'b0, hi_next} > ({1'b0, lo_next} + (ncts_pkg::ADDR_W + 1)'(1));
    mid_init = last_idx >> 1;
    init_cont = last_idx > ncts_pkg::ADDR_W'(1);
    hsel = (now < rdata) ? lo : hi;
    sel_sum = ncts_pkg::SEL_W'(hsel) + ncts_pkg::SEL_W'(skip);
    case (cmd.rd_sel)
      ncts_pkg::RD_LAST: raddr = last_idx;
      ncts_pkg::RD_INIT: raddr = init_cont ? mid_init : '0;
      ncts_pkg::RD_STEP: raddr = step_cont ? mid_next : lo_next;
      ncts_pkg::RD_SEL:  raddr = sel_sum[ncts_pkg::ADDR_W-1:0];
      default:           raddr = last_idx;
    endcase
    status.count_zero = (count == '0);
    status.last_le = !gt;
    status.init_cont = init_cont;
    status.step_cont = step_cont;
    status.sel_past = sel_sum >= ncts_pkg::SEL_W'(count);
    status.out_free = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_append && not_full) begin
      mem[count[ncts_pkg::ADDR_W-1:0]] <= req.time_value;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        count <= '0;
      end else if (cmd.do_append && not_full) begin
        count <= count + ncts_pkg::COUNT_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      now <= req.time_value;
      skip <= req.skip_count;
    end
    if (cmd.init_search) begin
      lo <= '0;
      hi <= last_idx;
      mid <= mid_init;
    end else if (cmd.step_search) begin
      lo <= lo_next;
      hi <= hi_next;
      mid <= mid_next;
    end
    if (cmd.set_result) begin
      res_status <= cmd.result_code;
      res_time <= (cmd.result_code == ncts_pkg::ST_FOUND) ? rdata : '0;
    end
    if (cmd.out_load) begin
      rsp.status <= res_status;
      rsp.contact_time <= res_time;
    end
  end

  `NCTS_ASSERT_NOW(a_step_interval, cmd.step_search,
    ({1'b0, hi} > ({1'b0, lo} + (ncts_pkg::ADDR_W + 1)'(1))),
    "Bisection step taken on an interval that is already closed.")
  `NCTS_ASSERT_NEXT(a_append_count, cmd.do_append && not_full,
    (count == $past(count) + ncts_pkg::COUNT_W'(1)),
    "Append to a list with room did not advance the count.")
  `NCTS_ASSERT_NOW(a_rsp_origin, $rose(rsp_valid), $past(cmd.out_load),
    "Result valid rose without an output load.")

endmodule

// ===== rtl/ncts_ctrl.sv =====
// Controller of the next contact time search unit: sequences clear, append
// and the query bisection. Depends on ncts_pkg.
`timescale 1ns / 1ps
`include "next_contact_time_search_unit_assert.svh"

module ncts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [1:0]           req_command,
  input  ncts_pkg::dp_status_t status,
  output ncts_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_SEARCH,
    S_LOCHK,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    cmd = '0;
    cmd.rd_sel = ncts_pkg::RD_LAST;
    cmd.result_code = ncts_pkg::ST_FOUND;
    state_next = state;
    req_ready = (state == S_IDLE);
    accept = req_valid && req_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_command)
            ncts_pkg::CMD_CLEAR: cmd.do_clear = 1'b1;
            ncts_pkg::CMD_APPEND: cmd.do_append = 1'b1;
            ncts_pkg::CMD_QUERY: begin
              cmd.latch_query = 1'b1;
              if (status.count_zero) begin
                cmd.set_result = 1'b1;
                cmd.result_code = ncts_pkg::ST_NONE;
                state_next = S_EMIT;
              end else begin
                state_next = S_LAST;
              end
            end
            default: ;
          endcase
        end
      end
      S_LAST: begin
        if (status.last_le) begin
          cmd.set_result = 1'b1;
          cmd.result_code = ncts_pkg::ST_NONE;
          state_next = S_EMIT;
        end else begin
          cmd.init_search = 1'b1;
          cmd.rd_sel = ncts_pkg::RD_INIT;
          state_next = status.init_cont ? S_SEARCH : S_LOCHK;
        end
      end
      S_SEARCH: begin
        cmd.step_search = 1'b1;
        cmd.rd_sel = ncts_pkg::RD_STEP;
        if (!status.step_cont) begin
          state_next = S_LOCHK;
        end
      end
      S_LOCHK: begin
        cmd.rd_sel = ncts_pkg::RD_SEL;
        if (status.sel_past) begin
          cmd.set_result = 1'b1;
          cmd.result_code = ncts_pkg::ST_PAST_END;
          state_next = S_EMIT;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.set_result = 1'b1;
        cmd.result_code = ncts_pkg::ST_FOUND;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `NCTS_ASSERT_NOW(a_load_free, cmd.out_load, status.out_free,
    "Output loaded while a result was still waiting.")
  `NCTS_ASSERT_NEXT(a_query_busy, accept && (req_command == ncts_pkg::CMD_QUERY),
    !req_ready, "New item taken while a query was in progress.")
  `NCTS_ASSERT_NOW(a_update_idle, cmd.do_clear || cmd.do_append, state == S_IDLE,
    "List update issued outside the idle state.")

endmodule

// ===== rtl/next_contact_time_search_unit.sv =====
// Top level of the next contact time search unit: joins controller and
// datapath. Depends on ncts_pkg, ncts_ctrl and ncts_datapath.
//
//   channel  direction  handshake              item
//   req      in         req_valid / req_ready  ncts_pkg::req_t (command, time, skip)
//   rsp      out        rsp_valid / rsp_ready  ncts_pkg::rsp_t (status, contact time)
//
// Clear and append are taken in the idle state; req_ready is high again on the next cycle.
// A query reads the last contact, then bisects the list with one dependent read of
// the contact memory per step, then checks the selected index and fetches that contact.
// An empty list or no later contact ends the query early, and a past-end index
// skips the fetch.
// Reset clears the count and the output valid flag; the memory needs no clearing.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module next_contact_time_search_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ncts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ncts_pkg::rsp_t rsp
);

  ncts_pkg::dp_cmd_t    cmd;
  ncts_pkg::dp_status_t status;

  ncts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_command (req.command),
    .status      (status),
    .cmd         (cmd)
  );

  ncts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== dv/ncts_contact_checker.sv =====
// Checker for the next contact time search unit: watches both channels, keeps its
// own copy of the contact list, predicts each query answer and compares it.
// Depends on ncts_pkg for the item types, sizes and codes.
`timescale 1ns / 1ps

module ncts_contact_checker
  import ncts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  logic [TIME_W-1:0] contact_mem [MAX_CONTACTS];
  int unsigned stored;
  rsp_t expected_answers[$];
  int errors = 0;

  // Bisection exactly as the block does it, so an unsorted list gives the same answer.
  function automatic rsp_t search_contact(logic [TIME_W-1:0] now, logic [SKIP_W-1:0] skip);
    int unsigned lo, hi, mid, sel;
    rsp_t ans;
    ans.status = ST_NONE;
    ans.contact_time = '0;
    if (stored == 0 || contact_mem[stored-1] <= now) return ans;
    lo = 0;
    hi = stored - 1;
    do begin
      mid = (lo + hi) >> 1;
      if (contact_mem[mid] > now) hi = mid;
      else lo = mid;
    end while (hi > lo + 1);
    if (now < contact_mem[lo]) hi = lo;
    sel = hi + skip;
    if (sel >= stored) begin
      ans.status = ST_PAST_END;
    end else begin
      ans.status = ST_FOUND;
      ans.contact_time = contact_mem[sel];
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      stored = 0;
      expected_answers.delete();
    end else begin
      if (req_valid && req_ready) begin
        case (req.command)
          CMD_CLEAR: stored = 0;
          CMD_APPEND: begin
            if (stored < MAX_CONTACTS) begin
              contact_mem[stored] = req.time_value;
              stored++;
            end
          end
          CMD_QUERY: expected_answers.push_back(search_contact(req.time_value, req.skip_count));
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result: status %0d, contact_time %0h", rsp.status, rsp.contact_time);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.contact_time !== want.contact_time) begin
            $error("contact_time: expected %0h, actual %0h", want.contact_time, rsp.contact_time);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    outstanding <= expected_answers.size();
  end

endmodule

// ===== dv/next_contact_time_search_unit_test.sv =====
// Testbench top for the next contact time search unit: drives list loads and
// queries with random gaps and stalls, and gives the verdict.
// Depends on ncts_pkg, next_contact_time_search_unit and ncts_contact_checker.
`timescale 1ns / 1ps

module next_contact_time_search_unit_test;
  import ncts_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 32;

  logic clk;
  logic rst = 1'b1;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  logic [TIME_W-1:0] list_mirror[$];

  next_contact_time_search_unit uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  ncts_contact_checker answer_check (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("** next_contact_time_search_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [TIME_W-1:0] stamp, logic [SKIP_W-1:0] skip);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= '{command: cmd, time_value: stamp, skip_count: skip};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (cmd == CMD_CLEAR) list_mirror.delete();
    else if (cmd == CMD_APPEND && list_mirror.size() < MAX_CONTACTS) list_mirror.push_back(stamp);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // The extra edge lets the checker count a query accepted on the last edge.
  task automatic wait_results_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_contact_set();
    int kind, n, idx, pick;
    logic [63:0] t_next;
    logic [TIME_W-1:0] now;
    logic [SKIP_W-1:0] skip;
    kind = $urandom_range(0, 9);
    calm = ($urandom_range(0, 4) == 0);
    n = (kind == 9) ? $urandom_range(25, 200) : $urandom_range(0, 24);
    // A set without a clear extends whatever list is already held.
    if (kind != 0) send_item(CMD_CLEAR, $urandom, SKIP_W'($urandom));
    t_next = ($urandom_range(0, 1) == 1) ? 64'($urandom) : 64'($urandom_range(0, 100));
    repeat (n) begin
      if (kind == 1) begin
        send_item(CMD_APPEND, $urandom, SKIP_W'($urandom));
      end else begin
        send_item(CMD_APPEND, t_next[TIME_W-1:0], SKIP_W'($urandom));
        t_next = t_next + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000));
        if (t_next > 64'hFFFF_FFFF) t_next = 64'hFFFF_FFFF;
      end
      if ($urandom_range(0, 19) == 0) send_item(CMD_UNUSED, $urandom, SKIP_W'($urandom));
    end
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 5);
      if (list_mirror.size() == 0 || pick == 0) begin
        now = $urandom;
      end else begin
        idx = $urandom_range(0, list_mirror.size() - 1);
        case (pick)
          1: now = list_mirror[idx];
          2: now = list_mirror[idx] - 1;
          3: now = '0;
          4: now = '1;
          default: now = list_mirror[idx] + 1;
        endcase
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) skip = SKIP_W'($urandom_range(0, 3));
      else if (pick < 9) skip = SKIP_W'($urandom_range(0, list_mirror.size() + 1));
      else skip = SKIP_W'($urandom_range(0, 65535));
      send_item(CMD_QUERY, now, skip);
    end
    if ($urandom_range(0, 7) == 0) wait_results_drained();
  endtask

  initial begin
    int gap;
    rsp_ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!rsp_valid);
        end
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin
    req_valid <= 1'b0;
    req <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list, an unused command, then a short sorted list with a duplicate.
    send_item(CMD_QUERY, 32'd0, 16'd0);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_APPEND, 32'd10, 16'd0);
    send_item(CMD_APPEND, 32'd20, 16'd0);
    send_item(CMD_APPEND, 32'd20, 16'd0);
    send_item(CMD_APPEND, 32'd40, 16'd0);
    send_item(CMD_APPEND, 32'hFFFF_FFFF, 16'd0);
    send_item(CMD_QUERY, 32'd0, 16'd0);
    send_item(CMD_QUERY, 32'd20, 16'd0);
    send_item(CMD_QUERY, 32'd19, 16'd1);
    send_item(CMD_QUERY, 32'd40, 16'd0);
    send_item(CMD_QUERY, 32'hFFFF_FFFF, 16'd0);
    send_item(CMD_QUERY, 32'd0, 16'd4);
    send_item(CMD_QUERY, 32'd0, 16'd5);
    send_item(CMD_QUERY, 32'd0, 16'hFFFF);
    send_item(CMD_CLEAR, 32'd0, 16'd0);
    send_item(CMD_QUERY, 32'd0, 16'd0);
    // An unsorted list still gets a fixed answer from the bisection.
    send_item(CMD_APPEND, 32'd50, 16'd0);
    send_item(CMD_APPEND, 32'd10, 16'd0);
    send_item(CMD_APPEND, 32'd30, 16'd0);
    send_item(CMD_QUERY, 32'd20, 16'd0);
    send_item(CMD_QUERY, 32'd5, 16'd0);
    wait_results_drained();

    while (items_sent < RANDOM_ITEMS) run_contact_set();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** next_contact_time_search_unit: PASSED **");
    end else begin
      $display("** next_contact_time_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
